@@ rtl/tall_glyph_page_packer_defines.svh @@
// Assertion macros for the glyph page packer.
`ifndef TALL_GLYPH_PAGE_PACKER_DEFINES_SVH
`define TALL_GLYPH_PAGE_PACKER_DEFINES_SVH

`ifndef SYNTHESIS

`define TGPP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tgpp assertion failed");

`define TGPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tgpp assertion failed");

`else

`define TGPP_ASSERT_SAME(lbl, clk, rst, ante, cons)

`define TGPP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ rtl/tgpp_pkg.sv @@
package tgpp_pkg;

  localparam int GLYPH_COUNT  = 64;
  localparam int GRID_COLUMNS = 7;
  localparam int GLYPH_BYTES  = 24;
  localparam int GLYPH_WIDTH  = 12;
  localparam int TEXT_ROWS    = 4;

  localparam int LINK_COUNT  = TEXT_ROWS * GRID_COLUMNS;
  localparam int LINK_AW     = $clog2(LINK_COUNT);
  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_BYTES;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic [7:0] COL_CMD  = 8'h80;
  localparam logic [7:0] PAGE_CMD = 8'h40;

  // step numbers inside a draw run
  localparam logic [4:0] STEP_COL0  = 5'd0;
  localparam logic [4:0] STEP_PAGE0 = 5'd1;
  localparam logic [4:0] STEP_COL1  = 5'd14;
  localparam logic [4:0] STEP_PAGE1 = 5'd15;
  localparam logic [4:0] STEP_DATA0 = 5'd2;
  localparam logic [4:0] STEP_DATA1 = 5'd16;
  localparam logic [4:0] STEP_LAST  = 5'd27;

  // how a byte is formed from the two store reads
  typedef logic [2:0] mode_t;
  localparam mode_t MODE_CMD   = 3'd0;
  localparam mode_t MODE_PLAIN = 3'd1;  // a
  localparam mode_t MODE_LO_LO = 3'd2;  // {b[3:0], a[3:0]}
  localparam mode_t MODE_SWAP  = 3'd3;  // {a[3:0], b[3:0]}
  localparam mode_t MODE_HI_LO = 3'd4;  // {b[3:0], a[7:4]}

  typedef struct packed {
    mode_t      mode;
    logic [7:0] cmd_byte;
    logic       zero_a;
    logic       zero_b;
    logic       last;
  } slot_t;

endpackage

@@ rtl/tgpp_ram.sv @@
module tgpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/tall_glyph_page_packer.sv @@
// Glyph page packer: draws 12x12 glyphs on a 7x4 character grid of an LCD
// with 8-pixel pages.
// Input channel s_axis: tuser = command (0 load glyph byte, 1 draw cell).
// A load gives no output. A draw records the glyph in
// the cell link table and emits 28 controller bytes on m_axis: column and
// page command plus 12 data bytes, twice; tuser marks data bytes, tlast the
// 28th byte. A draw on a column beyond the grid is dropped.
// After acceptance, a draw passes through the sequencer state, the read
// stage and the output register; bytes follow one per cycle while the
// receiver takes them, and the input is held through acceptance plus 28
// read issues, paced by the two-read glyph store read once per output byte.
// s_axis_tready is low while a draw run is issuing; the next transaction is
// taken as soon as the final byte's reads are issued.
// When the receiver stalls, the output register and the read stage hold and
// issuing pauses; no byte is lost.
// Reset clears the link table and all control state; the glyph store is not
// cleared and must be loaded before it is drawn from.
`include "tall_glyph_page_packer_defines.svh"

module tall_glyph_page_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] cell_column, [4:3] text_row, [10:5] glyph_index,
  // [15:11] byte_position, [23:16] byte_value
  input  logic [23:0] s_axis_tdata,
  // [0] command
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] lcd_byte
  output logic [7:0]  m_axis_tdata,
  // [0] is_data
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic [4:0] step;

  logic [2:0] in_col;
  logic [1:0] in_row;
  logic [5:0] in_idx;
  logic [4:0] in_pos;
  logic [7:0] in_val;

  assign in_col = s_axis_tdata[2:0];
  assign in_row = s_axis_tdata[4:3];
  assign in_idx = s_axis_tdata[10:5];
  assign in_pos = s_axis_tdata[15:11];
  assign in_val = s_axis_tdata[23:16];

  logic accept;
  logic load_ok;
  logic draw_ok;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign load_ok = accept && !s_axis_tuser && (in_pos < 5'(tgpp_pkg::GLYPH_BYTES))
                   && ({3'b000, in_idx} < 9'(tgpp_pkg::GLYPH_COUNT));
  assign draw_ok = accept && s_axis_tuser && (in_col < 3'(tgpp_pkg::GRID_COLUMNS));

  // link table
  logic [5:0] links [tgpp_pkg::LINK_COUNT];
  logic [tgpp_pkg::LINK_AW-1:0] link_wr;
  logic [tgpp_pkg::LINK_AW-1:0] link_rd;

  assign link_wr = tgpp_pkg::LINK_AW'(in_row * tgpp_pkg::GRID_COLUMNS + in_col);
  assign link_rd = tgpp_pkg::LINK_AW'((in_row ^ 2'b01) * tgpp_pkg::GRID_COLUMNS + in_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < tgpp_pkg::LINK_COUNT; n++) begin
        links[n] <= '0;
      end
    end else if (draw_ok) begin
      links[link_wr] <= in_idx;
    end
  end

  // captured draw
  logic [2:0] d_col;
  logic [1:0] d_row;
  logic [5:0] d_idx;
  logic [5:0] d_partner;

  always_ff @(posedge clk) begin
    if (draw_ok) begin
      d_col     <= in_col;
      d_row     <= in_row;
      d_idx     <= in_idx;
      d_partner <= links[link_rd];
    end
  end

  // issue stage
  logic out_free;
  logic slot_valid;
  logic issue;
  tgpp_pkg::slot_t slot;
  tgpp_pkg::slot_t slot_next;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign issue    = (state == ST_RUN) && (!slot_valid || out_free);

  logic second;
  logic [4:0] pix;
  logic [5:0] glyph_a;
  logic [5:0] glyph_b;
  logic [4:0] pos_a;
  logic [4:0] pos_b;
  logic [2:0] page0;
  logic [7:0] col_byte;

  assign second   = (step >= tgpp_pkg::STEP_COL1);
  assign pix      = second ? (step - tgpp_pkg::STEP_DATA1) : (step - tgpp_pkg::STEP_DATA0);
  assign page0    = (d_row[1] ? 3'd3 : 3'd0) + {2'b00, d_row[0]};
  assign col_byte = tgpp_pkg::COL_CMD | 8'(d_col * tgpp_pkg::GLYPH_WIDTH);

  always_comb begin
    glyph_a   = d_idx;
    pos_a     = pix;
    glyph_b   = d_idx;
    pos_b     = pix;
    slot_next = '0;
    case ({d_row[0], second})
      2'b00: begin
        slot_next.mode = tgpp_pkg::MODE_PLAIN;
      end
      2'b01: begin
        pos_a          = pix + 5'd12;
        glyph_b        = d_partner;
        slot_next.mode = tgpp_pkg::MODE_LO_LO;
      end
      2'b10: begin
        glyph_b        = d_partner;
        pos_b          = pix + 5'd12;
        slot_next.mode = tgpp_pkg::MODE_SWAP;
      end
      default: begin
        pos_b          = pix + 5'd12;
        slot_next.mode = tgpp_pkg::MODE_HI_LO;
      end
    endcase
    case (step)
      tgpp_pkg::STEP_COL0, tgpp_pkg::STEP_COL1: begin
        slot_next.mode     = tgpp_pkg::MODE_CMD;
        slot_next.cmd_byte = col_byte;
      end
      tgpp_pkg::STEP_PAGE0: begin
        slot_next.mode     = tgpp_pkg::MODE_CMD;
        slot_next.cmd_byte = tgpp_pkg::PAGE_CMD | {5'b00000, page0};
      end
      tgpp_pkg::STEP_PAGE1: begin
        slot_next.mode     = tgpp_pkg::MODE_CMD;
        slot_next.cmd_byte = tgpp_pkg::PAGE_CMD | {5'b00000, page0 + 3'd1};
      end
      default: begin
        slot_next.cmd_byte = '0;
      end
    endcase
    slot_next.zero_a = ({3'b000, glyph_a} >= 9'(tgpp_pkg::GLYPH_COUNT));
    slot_next.zero_b = ({3'b000, glyph_b} >= 9'(tgpp_pkg::GLYPH_COUNT));
    slot_next.last   = (step == tgpp_pkg::STEP_LAST);
  end

  logic [tgpp_pkg::STORE_AW-1:0] waddr;
  logic [tgpp_pkg::STORE_AW-1:0] raddr_a;
  logic [tgpp_pkg::STORE_AW-1:0] raddr_b;
  logic [7:0] rdata_a;
  logic [7:0] rdata_b;

  assign waddr   = tgpp_pkg::STORE_AW'(in_idx * tgpp_pkg::GLYPH_BYTES + in_pos);
  assign raddr_a = tgpp_pkg::STORE_AW'(glyph_a * tgpp_pkg::GLYPH_BYTES + pos_a);
  assign raddr_b = tgpp_pkg::STORE_AW'(glyph_b * tgpp_pkg::GLYPH_BYTES + pos_b);

  tgpp_ram #(
    .WIDTH (8),
    .DEPTH (tgpp_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (load_ok),
    .waddr   (waddr),
    .wdata   (in_val),
    .re      (issue),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else if (state == ST_IDLE) begin
      if (draw_ok) begin
        state <= ST_RUN;
        step  <= '0;
      end
    end else if (issue) begin
      if (step == tgpp_pkg::STEP_LAST) begin
        state <= ST_IDLE;
      end
      step <= step + 5'd1;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (issue) begin
      slot_valid <= 1'b1;
    end else if (out_free) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      slot <= slot_next;
    end
  end

  logic [7:0] byte_a;
  logic [7:0] byte_b;
  logic [7:0] lcd_byte;

  assign byte_a = slot.zero_a ? 8'h00 : rdata_a;
  assign byte_b = slot.zero_b ? 8'h00 : rdata_b;

  always_comb begin
    case (slot.mode)
      tgpp_pkg::MODE_PLAIN: lcd_byte = byte_a;
      tgpp_pkg::MODE_LO_LO: lcd_byte = {byte_b[3:0], byte_a[3:0]};
      tgpp_pkg::MODE_SWAP:  lcd_byte = {byte_a[3:0], byte_b[3:0]};
      tgpp_pkg::MODE_HI_LO: lcd_byte = {byte_b[3:0], byte_a[7:4]};
      default:              lcd_byte = slot.cmd_byte;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= slot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && slot_valid) begin
      m_axis_tdata <= lcd_byte;
      m_axis_tuser <= (slot.mode != tgpp_pkg::MODE_CMD);
      m_axis_tlast <= slot.last;
    end
  end

  `TGPP_ASSERT_SAME(a_last_is_data, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
  `TGPP_ASSERT_NEXT(a_draw_starts, clk, rst, draw_ok, (state == ST_RUN) && (step == 5'd0))
  `TGPP_ASSERT_NEXT(a_slot_holds, clk, rst, slot_valid && !out_free, slot_valid)

endmodule
